FILE: rtl/tsls_pkg.sv
// Package for the three-sigma level segmenter: constants, register indexes,
// multiply operation codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsls_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 12;
  localparam int INDEX_BITS_DEF  = 32;

  // fixed field widths
  localparam int MEAN_W     = 24;
  localparam int MAX_LEN_W  = 12;
  localparam int K_SIGMA_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  // register reset values
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 12'd801;
  localparam logic [K_SIGMA_W-1:0] K_SIGMA_RST = 4'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_K_SIGMA = 1'b1;

  // band test products, issued in this order
  typedef enum logic [2:0] {
    MUL_DD,     // d * d
    MUL_LEFT,   // d^2 * (n-1)
    MUL_NQ,     // n * Q
    MUL_SS,     // |S| * |S|, subtracted from n*Q
    MUL_RIGHT   // (nQ - S^2) * n * k^2
  } mul_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    load_in;
    logic    calc_d;
    logic    mul_start;
    mul_op_t mul_op;
    logic    mul_step;
    logic    mul_store;
    logic    div_start;
    logic    div_step;
    logic    take_first;
    logic    extend;
    logic    restart;
    logic    advance;
    logic    clear;
    logic    emit;
    logic    emit_final;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic first;
    logic over_len;
    logic reject;
    logic mul_done;
    logic div_done;
    logic eos;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/tsls_in_if.sv
// Input channel interface: valid/ready handshake with sample and end-of-stream.
// Standalone.
`timescale 1ns / 1ps
`default_nettype none
interface tsls_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_stream;

  modport source (output valid, sample, end_of_stream, input ready);
  modport sink   (input valid, sample, end_of_stream, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsls_out_if.sv
// Output channel interface: valid/ready handshake with one segment result.
// Standalone.
`timescale 1ns / 1ps
`default_nettype none
interface tsls_out_if #(
  parameter int INDEX_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [23:0]      mean_q8;
  logic [INDEX_BITS-1:0]   start_index;
  logic [INDEX_BITS-1:0]   end_index;
  logic                    stream_final;
  logic                    last_of_run;

  modport source (output valid, mean_q8, start_index, end_index, stream_final,
                  last_of_run, input ready);
  modport sink   (input valid, mean_q8, start_index, end_index, stream_final,
                  last_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsls_ctrl.sv
// Controller of the segmenter: sequences input, band test products, division
// and result emission. Depends on tsls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsls_ctrl
  import tsls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    IDLE, PREP, MUL_START, MUL_RUN, DECIDE, DIV, EMIT, END_CHECK
  } state_t;

  state_t  state, state_next;
  mul_op_t op, op_next;
  logic    final_seg, final_seg_next;

  // next-state and command decode
  always_comb begin
    state_next     = state;
    op_next        = op;
    final_seg_next = final_seg;
    cmd            = '0;
    cmd.mul_op     = op;
    cmd.emit_final = final_seg;
    case (state)
      IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_in  = 1'b1;
        if (sts.in_valid) state_next = PREP;
      end
      PREP: begin
        if (sts.first) begin
          cmd.take_first = 1'b1;
          state_next     = END_CHECK;
        end else if (sts.over_len) begin
          cmd.div_start  = 1'b1;
          final_seg_next = 1'b0;
          state_next     = DIV;
        end else begin
          cmd.calc_d = 1'b1;
          op_next    = MUL_DD;
          state_next = MUL_START;
        end
      end
      MUL_START: begin
        cmd.mul_start = 1'b1;
        state_next    = MUL_RUN;
      end
      MUL_RUN: begin
        if (sts.mul_done) begin
          cmd.mul_store = 1'b1;
          case (op)
            MUL_DD:   begin op_next = MUL_LEFT;  state_next = MUL_START; end
            MUL_LEFT: begin op_next = MUL_NQ;    state_next = MUL_START; end
            MUL_NQ:   begin op_next = MUL_SS;    state_next = MUL_START; end
            MUL_SS:   begin op_next = MUL_RIGHT; state_next = MUL_START; end
            default:  state_next = DECIDE;
          endcase
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      DECIDE: begin
        if (sts.reject) begin
          cmd.div_start  = 1'b1;
          final_seg_next = 1'b0;
          state_next     = DIV;
        end else begin
          cmd.extend = 1'b1;
          state_next = END_CHECK;
        end
      end
      DIV: begin
        if (sts.div_done) state_next = EMIT;
        else cmd.div_step = 1'b1;
      end
      EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (final_seg) begin
            cmd.clear  = 1'b1;
            state_next = IDLE;
          end else begin
            cmd.restart = 1'b1;
            state_next  = END_CHECK;
          end
        end
      end
      END_CHECK: begin
        if (sts.eos) begin
          cmd.div_start  = 1'b1;
          final_seg_next = 1'b1;
          state_next     = DIV;
        end else begin
          cmd.advance = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      op        <= MUL_DD;
      final_seg <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      final_seg <= final_seg_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tsls_dp.sv
// Datapath of the segmenter: configuration, segment statistics, shift-add
// multiplier, restoring divider and output register. Depends on tsls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsls_dp
  import tsls_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cmd_t                          cmd,
  output sts_t                               sts,
  input  wire logic                          in_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_eos,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [MEAN_W-1:0]           out_mean,
  output logic [INDEX_BITS-1:0]              out_start,
  output logic [INDEX_BITS-1:0]              out_end,
  output logic                               out_final,
  output logic                               out_last
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int SUM_W = SB + CB;
  localparam int SQ_W  = 2 * SB + CB;
  localparam int DS_W  = SUM_W + 2;
  localparam int CMP_W = 2 * SB + 3 * CB + 8;
  localparam int NK_W  = CB + 8;
  localparam int MB_W  = (SUM_W > NK_W) ? SUM_W : NK_W;
  localparam int DIV_W = SUM_W + 8;
  localparam int DC_W  = $clog2(DIV_W + 1);
  localparam int LIM_W = ((CB > MAX_LEN_W) ? CB : MAX_LEN_W) + 1;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  // configuration and segment state
  logic [MAX_LEN_W-1:0]    max_len;
  logic [K_SIGMA_W-1:0]    k_sigma;
  logic [INDEX_BITS-1:0]   sample_index;
  logic [INDEX_BITS-1:0]   segment_start;
  logic [CB-1:0]           segment_count;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]         running_square_sum;
  logic signed [SB-1:0]    previous_sample;

  // current item
  logic signed [SB-1:0]    x;
  logic                    eos;
  logic [2*SB-1:0]         x2;
  logic [CB:0]             n;
  logic signed [SUM_W-1:0] s;
  logic [SQ_W-1:0]         q;
  logic [SUM_W-1:0]        d;

  // multiplier
  mul_op_t                 mul_op;
  logic [CMP_W-1:0]        mcand, acc, t, left, right;
  logic [MB_W-1:0]         mplier;

  // divider
  logic [DIV_W-1:0]        dq;
  logic [CB-1:0]           rem;
  logic [DC_W-1:0]         dcnt;
  logic                    dneg;

  logic signed [2*SB-1:0]  xsq_in, psq;
  logic [LIM_W-1:0]        lim, max_ext;
  logic signed [DS_W-1:0]  nx, diff, absd;
  logic [SUM_W-1:0]        s_abs, rs_abs;
  logic [7:0]              kk;
  logic [NK_W-1:0]         nkk;
  logic [CB:0]             rem_sh;
  logic signed [DIV_W:0]   mean_full;

  // combinational helpers
  always_comb begin
    xsq_in  = in_sample * in_sample;
    psq     = previous_sample * previous_sample;
    max_ext = LIM_W'(max_len);
    if (max_ext < LIM_W'(2)) lim = LIM_W'(2);
    else if (max_ext > LIM_W'(CMAX)) lim = LIM_W'(CMAX);
    else lim = max_ext;
    nx      = $signed({{(DS_W-CB-1){1'b0}}, n}) * DS_W'(x);
    diff    = nx - DS_W'(s);
    absd    = diff[DS_W-1] ? -diff : diff;
    s_abs   = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    rs_abs  = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
    kk      = 8'(k_sigma) * 8'(k_sigma);
    nkk     = NK_W'(n[CB-1:0]) * NK_W'(kk);
    rem_sh  = {rem, dq[DIV_W-1]};
    mean_full = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  end

  // status to controller
  always_comb begin
    sts.in_valid = in_valid;
    sts.first    = (segment_count == '0);
    sts.over_len = (LIM_W'(n) > lim);
    sts.reject   = (left > right);
    sts.mul_done = (mplier == '0);
    sts.div_done = (dcnt == '0);
    sts.eos      = eos;
    sts.out_free = !out_valid || out_ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RST;
      k_sigma <= K_SIGMA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LEN: max_len <= cfg_data[MAX_LEN_W-1:0];
        REG_K_SIGMA: k_sigma <= cfg_data[K_SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  // segment state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sample_index       <= '0;
      segment_start      <= '0;
      segment_count      <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      previous_sample    <= '0;
    end else begin
      if (cmd.take_first) begin
        segment_start      <= sample_index;
        segment_count      <= CB'(1);
        running_sum        <= SUM_W'(x);
        running_square_sum <= SQ_W'(x2);
      end
      if (cmd.extend) begin
        segment_count      <= n[CB-1:0];
        running_sum        <= s;
        running_square_sum <= q;
      end
      if (cmd.restart) begin
        segment_start      <= sample_index - 1'b1;
        segment_count      <= CB'(2);
        running_sum        <= SUM_W'(previous_sample) + SUM_W'(x);
        running_square_sum <= SQ_W'($unsigned(psq)) + SQ_W'(x2);
      end
      if (cmd.advance) begin
        previous_sample <= x;
        sample_index    <= sample_index + 1'b1;
      end
    end
  end

  // item capture and extended-segment sums
  always_ff @(posedge clk) begin
    if (cmd.load_in && in_valid) begin
      x   <= in_sample;
      eos <= in_eos;
      x2  <= $unsigned(xsq_in);
      n   <= {1'b0, segment_count} + 1'b1;
      s   <= running_sum + SUM_W'(in_sample);
      q   <= running_square_sum + SQ_W'($unsigned(xsq_in));
    end
    if (cmd.calc_d) d <= absd[SUM_W-1:0];
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (cmd.mul_start) begin
      mul_op <= cmd.mul_op;
      acc    <= '0;
      case (cmd.mul_op)
        MUL_DD:    begin mcand <= CMP_W'(d);     mplier <= MB_W'(d);        end
        MUL_LEFT:  begin mcand <= t;             mplier <= MB_W'(n - 1'b1); end
        MUL_NQ:    begin mcand <= CMP_W'(q);     mplier <= MB_W'(n);        end
        MUL_SS:    begin mcand <= CMP_W'(s_abs); mplier <= MB_W'(s_abs);    end
        default:   begin mcand <= t;             mplier <= MB_W'(nkk);      end
      endcase
    end else if (cmd.mul_step) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  // product destinations
  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (mul_op)
        MUL_DD:   t     <= acc;
        MUL_LEFT: left  <= acc;
        MUL_NQ:   t     <= acc;
        MUL_SS:   t     <= t - acc;
        default:  right <= acc;
      endcase
    end
  end

  // restoring divider for the mean, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dq   <= {rs_abs, 8'd0};
      rem  <= '0;
      dneg <= running_sum[SUM_W-1];
      dcnt <= DC_W'(DIV_W);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, segment_count}) begin
        rem <= CB'(rem_sh - {1'b0, segment_count});
        dq  <= {dq[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CB-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_mean  <= MEAN_W'(mean_full);
      out_start <= segment_start;
      out_end   <= cmd.emit_final ? sample_index : sample_index - 1'b1;
      out_final <= cmd.emit_final;
      out_last  <= cmd.emit_final || !eos;
    end
  end

  // checks
  a_emit_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (dcnt == '0))
    else $error("result emitted before division finished");
  a_store_when_done: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_store |-> (mplier == '0))
    else $error("product stored while multiplier still busy");
  a_band_in_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.calc_d |-> (LIM_W'(n) <= lim))
    else $error("band test started on an over-length segment");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result dropped");

endmodule
`default_nettype wire

FILE: rtl/three_sigma_level_segmenter_top.sv
// Top level of the three-sigma level segmenter: channel interfaces, config port,
// controller and datapath. Depends on tsls_pkg, tsls_in_if, tsls_out_if, tsls_ctrl, tsls_dp.
// Per item: the first sample of a segment needs no band test; a band test runs five
//   shift-add products in turn, each one multiplier bit per step; each result adds a
//   36-step divide and handoff, plus any wait on a full output register.
// One item at a time; throughput is set by the shared multiplier and divider.
// Reset (rst, synchronous): no open segment, indices zero, max_len 801, k_sigma 3.
`timescale 1ns / 1ps
`default_nettype none
module three_sigma_level_segmenter_top
  import tsls_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  tsls_in_if.sink                    in_ch,
  tsls_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign in_ch.ready = cmd.in_ready;

  tsls_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  tsls_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.sample),
    .in_eos    (in_ch.end_of_stream),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_mean  (out_ch.mean_q8),
    .out_start (out_ch.start_index),
    .out_end   (out_ch.end_index),
    .out_final (out_ch.stream_final),
    .out_last  (out_ch.last_of_run)
  );

endmodule
`default_nettype wire

FILE: sim/tsls_checker.sv
// Segment checker: watches the input and result channels, predicts segment results
// from the accepted samples and the config writes, and compares them field by field.
// Depends on tsls_pkg, tsls_in_if, tsls_out_if.
`timescale 1ns / 1ps
`default_nettype none
module tsls_checker
  import tsls_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  tsls_in_if                         in_ch,
  tsls_out_if                        out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic signed [23:0] mean_q8;
    logic [31:0]        start_index;
    logic [31:0]        end_index;
    logic               stream_final;
    logic               last_of_run;
  } segment_t;

  segment_t seg_q[$];

  // model state
  logic [11:0] max_len;
  logic [3:0]  k_sigma;
  logic [31:0] sample_idx;
  logic [31:0] seg_start;
  int unsigned seg_count;
  longint      sum;
  longint      sq_sum;
  longint      prev_x;

  function automatic segment_t segment_of(logic [31:0] s, logic [31:0] e, logic fin,
                                          logic last);
    segment_t r;
    longint mag;
    longint m;
    mag = (sum < 0 ? -sum : sum) * 256 / (seg_count == 0 ? 1 : seg_count);
    m = sum < 0 ? -mag : mag;
    r.mean_q8 = m[23:0];
    r.start_index = s;
    r.end_index = e;
    r.stream_final = fin;
    r.last_of_run = last;
    return r;
  endfunction

  // exact band test on 128-bit unsigned products
  function automatic bit outside_band(longint x, longint n, longint s, longint q);
    logic [127:0] d;
    logic [127:0] left;
    logic [127:0] right;
    logic [127:0] sa;
    d = (n * x - s) < 0 ? -(n * x - s) : (n * x - s);
    sa = s < 0 ? -s : s;
    left = d * d * (n - 1);
    right = (128'(n) * 128'(q) - sa * sa) * 128'(n * k_sigma * k_sigma);
    return left > right;
  endfunction

  task automatic predict_sample(logic signed [15:0] smp, logic eos);
    longint x;
    longint n;
    longint s;
    longint q;
    longint lim;
    logic [31:0] idx;
    x = smp;
    idx = sample_idx;
    lim = max_len < 2 ? 2 : max_len;
    if (seg_count == 0) begin
      seg_start = idx;
      seg_count = 1;
      sum = x;
      sq_sum = x * x;
    end else begin
      n = seg_count + 1;
      s = sum + x;
      q = sq_sum + x * x;
      if (n > lim || outside_band(x, n, s, q)) begin
        seg_q.insert(seg_q.size(), segment_of(seg_start, idx - 1, 1'b0, !eos));
        seg_start = idx - 1;
        seg_count = 2;
        sum = prev_x + x;
        sq_sum = prev_x * prev_x + x * x;
      end else begin
        seg_count = n;
        sum = s;
        sq_sum = q;
      end
    end
    prev_x = x;
    sample_idx = idx + 1;
    if (eos) begin
      seg_q.insert(seg_q.size(), segment_of(seg_start, idx, 1'b1, 1'b1));
      sample_idx = '0;
      seg_start = '0;
      seg_count = 0;
      sum = 0;
      sq_sum = 0;
      prev_x = 0;
    end
  endtask

  // watch config writes, samples and results
  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (rst) begin
      max_len = MAX_LEN_RST;
      k_sigma = K_SIGMA_RST;
      sample_idx = '0;
      seg_start = '0;
      seg_count = 0;
      sum = 0;
      sq_sum = 0;
      prev_x = 0;
      seg_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_LEN) max_len = cfg_data[MAX_LEN_W-1:0];
        else if (cfg_index == REG_K_SIGMA) k_sigma = cfg_data[K_SIGMA_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.mean_q8, out_ch.start_index, out_ch.end_index,
                out_ch.stream_final, out_ch.last_of_run};
        if (seg_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          want = seg_q.pop_front();
          if (got != want) begin
            if (got.mean_q8 != want.mean_q8)
              $error("mean_q8 exp %0d got %0d", want.mean_q8, got.mean_q8);
            if (got.start_index != want.start_index)
              $error("start_index exp %0d got %0d", want.start_index, got.start_index);
            if (got.end_index != want.end_index)
              $error("end_index exp %0d got %0d", want.end_index, got.end_index);
            if (got.stream_final != want.stream_final)
              $error("stream_final exp %0d got %0d", want.stream_final, got.stream_final);
            if (got.last_of_run != want.last_of_run)
              $error("last_of_run exp %0d got %0d", want.last_of_run, got.last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_sample(in_ch.sample, in_ch.end_of_stream);
    end
    pending <= seg_q.size();
  end

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench top for the three-sigma level segmenter: clock, reset, config writes,
// sample stimulus with random idling, and the verdict. Depends on tsls_pkg, the
// channel interfaces, tsls_checker and three_sigma_level_segmenter_top.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tsls_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int   fail_count;
  int   pending;
  bit   no_idle = 1'b0;
  longint cycles = 0;

  tsls_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  tsls_out_if #(.INDEX_BITS(32))  out_ch ();

  three_sigma_level_segmenter_top dut (
    .clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we, .cfg_index, .cfg_data
  );

  tsls_checker chk (
    .clk, .rst, .in_ch, .out_ch, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b0;
  end

  // result side stalls
  always @(posedge clk) out_ch.ready <= no_idle || ($urandom_range(99) >= 35);

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one sample transaction, with random gaps before it; valid stays up after
  // acceptance until the next gap or settle() drops it
  task automatic send_sample(logic signed [15:0] smp, logic eos);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drain results, then let a band test in flight finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // one level run with noise; a level shift every so often
  task automatic random_stream(int len, int spread);
    int level;
    int v;
    level = $urandom_range(65535) - 32768;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) level = $urandom_range(65535) - 32768;
      if ($urandom_range(29) == 0) v = $urandom_range(65535) - 32768;
      else v = level + $urandom_range(2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_sample(16'(v), i == len - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, flat run, a step, single-sample stream, close plus flush
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh0010, 1'b0);
    send_sample(16'sh0011, 1'b0);
    send_sample(16'sh0010, 1'b0);
    send_sample(16'sh0011, 1'b0);
    send_sample(16'sh5000, 1'b0);
    send_sample(16'sh5001, 1'b0);
    send_sample(-16'sd1, 1'b1);
    settle();

    // tiny max_len forces closes; zero k_sigma narrows band to nothing
    write_reg(REG_MAX_LEN, 12'd0);
    write_reg(REG_K_SIGMA, 4'd0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd6, 1'b0);
    send_sample(-16'sd7, 1'b1);
    settle();
    write_reg(REG_MAX_LEN, 12'd4095);
    write_reg(REG_K_SIGMA, 4'd15);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    settle();

    // random phases over several settings
    sent = 0;
    for (int ph = 0; sent < 500; ph++) begin
      case (ph % 4)
        0: begin write_reg(REG_MAX_LEN, 12'd2); write_reg(REG_K_SIGMA, 4'd1); end
        1: begin write_reg(REG_MAX_LEN, 12'd4095); write_reg(REG_K_SIGMA, 4'd15); end
        2: begin
          write_reg(REG_MAX_LEN, 12'($urandom_range(4095)));
          write_reg(REG_K_SIGMA, 4'($urandom_range(15)));
        end
        default: begin write_reg(REG_MAX_LEN, 12'd801); write_reg(REG_K_SIGMA, 4'd3); end
      endcase
      no_idle = (ph == 5);
      for (int r = 0; r < 3; r++) begin
        random_stream($urandom_range(40, 1), (ph % 3 == 0) ? 40000 : $urandom_range(200));
        sent += 20;
      end
      settle();
    end
    no_idle = 1'b0;

    settle();
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

FILE: three_sigma_level_segmenter_top.f
rtl/tsls_pkg.sv
rtl/tsls_in_if.sv
rtl/tsls_out_if.sv
rtl/tsls_ctrl.sv
rtl/tsls_dp.sv
rtl/three_sigma_level_segmenter_top.sv
sim/tsls_checker.sv
sim/tb.sv
